>>> hw/rtl/mbrs_pkg.sv
package mbrs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_REG_COUNT = 2;
    localparam int DEF_MAX_FRAME = 256;

    // Modbus function codes that the slave serves.
    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;

    // Modbus CRC-16, reflected form.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Only requests of this length are served; only the first bytes are kept.
    localparam int HDR_BYTES = 6;
    localparam int REQ_LEN   = 8;

    // Configuration register reset values.
    localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;
    localparam logic [15:0] GAP_RESET      = 16'd9001;

    // Configuration register index, taken from paddr[2].
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_GAP      = 1'b1;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_INREG = 2'd2
    } t_action;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_RX_CRC    = 7'b0000010,
        S_CHECK     = 7'b0000100,
        S_TX_LOAD   = 7'b0001000,
        S_TX_CRC    = 7'b0010000,
        S_TX_CRC_LO = 7'b0100000,
        S_TX_CRC_HI = 7'b1000000
    } t_state;

endpackage

>>> hw/rtl/modbus_rtu_register_slave.sv
// Modbus RTU register slave.
// The input stream carries one item per event: tuser selects a received UART byte, a
// timer tick, or an update of one input register. Bytes are gathered into a request
// frame while the Modbus CRC-16 runs over them one bit per clock. When gap_ticks ticks
// pass with no byte, the frame ends; a valid 8-byte request for this device with
// function 3, 4 or 6 is answered, anything else is dropped without a reply.
// Each reply byte leaves on the output stream as one item, tlast on the final CRC byte.
// A received byte is accepted and then stepped through the CRC bit by bit; a tick or a
// register update needs only its acceptance. The tick that closes a frame leads to a
// check, then each reply data byte is sent and passes through the same bit-serial CRC
// unit, while the two CRC bytes are sent without CRC steps. s_axis_tready is low while
// a byte's CRC, the frame check or a reply is in progress. The output holds one byte in
// a register; when the receiver stalls the reply waits on that register, and no further
// input is taken until the last reply byte is loaded into it. Synchronous reset clears
// the frame, the Modbus registers and the configuration to its defaults (address 1, gap
// 9001 ticks). The user must write the APB port while idle; the block does not check it.
module modbus_rtu_register_slave #(
    parameter int REG_COUNT = mbrs_pkg::DEF_REG_COUNT,
    parameter int MAX_FRAME = mbrs_pkg::DEF_MAX_FRAME
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], reg_index[8], reg_value[24:9], zeros
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // Reply stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RI_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int LEN_W = $clog2(MAX_FRAME + 2);
    localparam int TX_W  = $clog2(2 * REG_COUNT + 4);

    mbrs_pkg::t_state r_state, n_state;

    logic [7:0]       r_dev_addr, n_dev_addr;
    logic [15:0]      r_gap, n_gap;

    logic [LEN_W-1:0] r_frame_len, n_frame_len;
    logic [7:0]       r_hdr [mbrs_pkg::HDR_BYTES];
    logic [7:0]       n_hdr [mbrs_pkg::HDR_BYTES];
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_silence, n_silence;
    logic             r_open, n_open;
    logic [15:0]      r_hold [REG_COUNT];
    logic [15:0]      n_hold [REG_COUNT];
    logic [15:0]      r_inreg [REG_COUNT];
    logic [15:0]      n_inreg [REG_COUNT];

    // Bit-serial CRC and reply sequencing.
    logic [7:0]       r_shift, n_shift;
    logic [2:0]       r_bit_cnt, n_bit_cnt;
    logic             r_is_read, n_is_read;
    logic             r_bank_in, n_bank_in;
    logic             r_hi, n_hi;
    logic [RI_W-1:0]  r_reg_ptr, n_reg_ptr;
    logic [TX_W-1:0]  r_byte_idx, n_byte_idx;
    logic [TX_W-1:0]  r_byte_total, n_byte_total;
    logic [7:0]       r_count_byte, n_count_byte;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic             w_accept;
    logic             w_out_free;
    logic [15:0]      w_crc_step;
    logic [16:0]      w_sil_inc;
    logic [15:0]      w_addr;
    logic [15:0]      w_word;
    logic             w_frame_ok;
    logic             w_addr_ok;
    logic             w_read_ok;
    logic [15:0]      w_reg_word;
    logic [7:0]       w_tx_byte;
    logic [RI_W-1:0]  w_in_idx;

    assign s_axis_tready = (r_state == mbrs_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mbrs_pkg::CFG_GAP) ? {16'd0, r_gap} : {24'd0, r_dev_addr};

    // One step of the reflected CRC: the data bit enters at the low end.
    assign w_crc_step = {1'b0, r_crc[15:1]}
                      ^ (((r_crc[0] ^ r_shift[0]) == 1'b1) ? mbrs_pkg::CRC_POLY : 16'h0000);

    assign w_sil_inc = {1'b0, r_silence} + 17'd1;
    assign w_in_idx  = RI_W'(s_axis_tdata[8]);

    // Request fields, big-endian on the wire.
    assign w_addr     = {r_hdr[2], r_hdr[3]};
    assign w_word     = {r_hdr[4], r_hdr[5]};
    assign w_frame_ok = (r_frame_len == LEN_W'(mbrs_pkg::REQ_LEN)) && (r_crc == 16'h0000)
                     && (r_hdr[0] == r_dev_addr);
    assign w_addr_ok  = (w_addr < 16'(REG_COUNT));
    assign w_read_ok  = (w_word != 16'd0) && w_addr_ok
                     && (({1'b0, w_addr} + {1'b0, w_word}) <= 17'(REG_COUNT));

    assign w_reg_word = r_bank_in ? r_inreg[r_reg_ptr] : r_hold[r_reg_ptr];

    // Reply byte at the current position. A write echoes the request header; a read
    // echoes address and function, then the byte count, then register data high first.
    always_comb begin
        if (!r_is_read || (r_byte_idx < TX_W'(2))) begin
            w_tx_byte = r_hdr[r_byte_idx[2:0]];
        end else if (r_byte_idx == TX_W'(2)) begin
            w_tx_byte = r_count_byte;
        end else if (r_hi) begin
            w_tx_byte = w_reg_word[15:8];
        end else begin
            w_tx_byte = w_reg_word[7:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_dev_addr   = r_dev_addr;
        n_gap        = r_gap;
        n_frame_len  = r_frame_len;
        n_hdr        = r_hdr;
        n_crc        = r_crc;
        n_silence    = r_silence;
        n_open       = r_open;
        n_hold       = r_hold;
        n_inreg      = r_inreg;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_is_read    = r_is_read;
        n_bank_in    = r_bank_in;
        n_hi         = r_hi;
        n_reg_ptr    = r_reg_ptr;
        n_byte_idx   = r_byte_idx;
        n_byte_total = r_byte_total;
        n_count_byte = r_count_byte;
        n_out_valid  = m_axis_tready ? 1'b0 : r_out_valid;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;

        if (psel && penable && pwrite) begin
            if (paddr[2] == mbrs_pkg::CFG_GAP) begin
                n_gap = pwdata[15:0];
            end else begin
                n_dev_addr = pwdata[7:0];
            end
        end

        unique case (r_state)
            mbrs_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (s_axis_tuser)
                        mbrs_pkg::ACT_BYTE: begin
                            if (r_frame_len < LEN_W'(mbrs_pkg::HDR_BYTES)) begin
                                n_hdr[r_frame_len[2:0]] = s_axis_tdata[7:0];
                            end
                            if (r_frame_len <= LEN_W'(MAX_FRAME)) begin
                                n_frame_len = r_frame_len + LEN_W'(1);
                            end
                            n_shift   = s_axis_tdata[7:0];
                            n_bit_cnt = 3'd0;
                            n_silence = 16'd0;
                            n_open    = 1'b1;
                            n_state   = mbrs_pkg::S_RX_CRC;
                        end
                        mbrs_pkg::ACT_TICK: begin
                            if (r_open) begin
                                n_silence = w_sil_inc[15:0];
                                // A gap of zero ends the frame on the first tick as well.
                                if (w_sil_inc >= {1'b0, r_gap}) begin
                                    n_state = mbrs_pkg::S_CHECK;
                                end
                            end
                        end
                        mbrs_pkg::ACT_INREG: begin
                            if (32'(s_axis_tdata[8]) < 32'(REG_COUNT)) begin
                                n_inreg[w_in_idx] = s_axis_tdata[24:9];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mbrs_pkg::S_RX_CRC: begin
                n_crc     = w_crc_step;
                n_shift   = {1'b0, r_shift[7:1]};
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    n_state = mbrs_pkg::S_IDLE;
                end
            end
            mbrs_pkg::S_CHECK: begin
                // The receiver is cleared whether or not the frame is served. The reply
                // CRC starts from the same initial value in the shared CRC register.
                n_frame_len  = '0;
                n_silence    = 16'd0;
                n_open       = 1'b0;
                n_crc        = mbrs_pkg::CRC_INIT;
                n_byte_idx   = '0;
                n_hi         = 1'b1;
                n_reg_ptr    = w_addr[RI_W-1:0];
                n_count_byte = {w_word[6:0], 1'b0};
                n_bank_in    = (r_hdr[1] == mbrs_pkg::FN_READ_INPUT);
                n_state      = mbrs_pkg::S_IDLE;
                if (w_frame_ok) begin
                    if (((r_hdr[1] == mbrs_pkg::FN_READ_HOLDING)
                            || (r_hdr[1] == mbrs_pkg::FN_READ_INPUT)) && w_read_ok) begin
                        n_is_read    = 1'b1;
                        n_byte_total = TX_W'(3) + {w_word[TX_W-2:0], 1'b0};
                        n_state      = mbrs_pkg::S_TX_LOAD;
                    end else if ((r_hdr[1] == mbrs_pkg::FN_WRITE_SINGLE) && w_addr_ok) begin
                        n_hold[w_addr[RI_W-1:0]] = w_word;
                        n_is_read    = 1'b0;
                        n_byte_total = TX_W'(mbrs_pkg::HDR_BYTES);
                        n_state      = mbrs_pkg::S_TX_LOAD;
                    end
                end
            end
            mbrs_pkg::S_TX_LOAD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_tx_byte;
                    n_out_last  = 1'b0;
                    n_shift     = w_tx_byte;
                    n_bit_cnt   = 3'd0;
                    n_byte_idx  = r_byte_idx + TX_W'(1);
                    if (r_is_read && (r_byte_idx >= TX_W'(3))) begin
                        n_hi = !r_hi;
                        if (!r_hi) begin
                            n_reg_ptr = r_reg_ptr + RI_W'(1);
                        end
                    end
                    n_state = mbrs_pkg::S_TX_CRC;
                end
            end
            mbrs_pkg::S_TX_CRC: begin
                n_crc     = w_crc_step;
                n_shift   = {1'b0, r_shift[7:1]};
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    n_state = (r_byte_idx == r_byte_total) ? mbrs_pkg::S_TX_CRC_LO
                                                           : mbrs_pkg::S_TX_LOAD;
                end
            end
            mbrs_pkg::S_TX_CRC_LO: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_crc[7:0];
                    n_out_last  = 1'b0;
                    n_state     = mbrs_pkg::S_TX_CRC_HI;
                end
            end
            mbrs_pkg::S_TX_CRC_HI: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_crc[15:8];
                    n_out_last  = 1'b1;
                    n_crc       = mbrs_pkg::CRC_INIT;
                    n_state     = mbrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbrs_pkg::S_IDLE;
            r_dev_addr  <= mbrs_pkg::DEV_ADDR_RESET;
            r_gap       <= mbrs_pkg::GAP_RESET;
            r_frame_len <= '0;
            r_crc       <= mbrs_pkg::CRC_INIT;
            r_silence   <= 16'd0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_hold[i]  <= 16'd0;
                r_inreg[i] <= 16'd0;
            end
        end else begin
            r_state     <= n_state;
            r_dev_addr  <= n_dev_addr;
            r_gap       <= n_gap;
            r_frame_len <= n_frame_len;
            r_crc       <= n_crc;
            r_silence   <= n_silence;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            r_hold      <= n_hold;
            r_inreg     <= n_inreg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr        <= n_hdr;
        r_shift      <= n_shift;
        r_bit_cnt    <= n_bit_cnt;
        r_is_read    <= n_is_read;
        r_bank_in    <= n_bank_in;
        r_hi         <= n_hi;
        r_reg_ptr    <= n_reg_ptr;
        r_byte_idx   <= n_byte_idx;
        r_byte_total <= n_byte_total;
        r_count_byte <= n_count_byte;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Stream-level test of the Modbus RTU register slave.
// A driver feeds queued events (UART bytes, timer ticks, input register updates and
// the unused action code) into the input stream. A monitor watches both streams:
// every accepted event goes through a cycle-free model of the slave, which queues
// the reply bytes it expects, and every accepted reply byte is compared against the
// oldest of those. Configuration changes only happen once both streams are quiet.
module testbench;
    import mbrs_pkg::*;

    localparam int NUM_REGS = DEF_REG_COUNT;
    localparam int FRAME_CAP = DEF_MAX_FRAME;
    // The two-bit action field has one code that the slave must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Cycles to let pass after the last reply byte before touching the APB port.
    // This leaves room for a byte's CRC and a closing check to finish.
    localparam int QUIET_CYCLES = 32;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  b;
        logic        idx;
        logic [15:0] val;
        int          lag;
    } rx_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // rx_byte[7:0], reg_index[8], reg_value[24:9], zeros
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // tx_byte[7:0]
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_register_slave #(
        .REG_COUNT(NUM_REGS),
        .MAX_FRAME(FRAME_CAP)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending input events and the reply bytes the model expects, oldest first.
    rx_event_t   rx_events[$];
    reply_byte_t reply_bytes_due[$];

    int err_count = 0;
    int events_queued = 0;
    int items_taken = 0;
    int bytes_seen = 0;
    int frames_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;

    bit src_idle_on = 1'b1;
    bit hold_req = 1'b0;

    // Model state of the slave: configuration, receiver and register banks.
    logic [7:0]  m_dev = DEV_ADDR_RESET;
    logic [15:0] m_gap = GAP_RESET;
    int          m_len = 0;
    logic [7:0]  m_hdr [0:HDR_BYTES-1];
    logic [15:0] m_crc = CRC_INIT;
    int          m_silence = 0;
    bit          m_open = 1'b0;
    logic [15:0] m_hold [0:NUM_REGS-1] = '{default: 16'h0000};
    logic [15:0] m_inreg [0:NUM_REGS-1] = '{default: 16'h0000};

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advances the model by one accepted event and queues the reply bytes it causes.
    task automatic predict_reply(input logic [1:0] act, input logic [7:0] b,
                                 input logic idx, input logic [15:0] val);
        logic [7:0]  msg [0:8];
        logic [15:0] c;
        int          n;
        int          start;
        int          count;
        case (act)
            ACT_BYTE: begin
                if (m_len < HDR_BYTES) begin
                    m_hdr[m_len] = b;
                end
                m_crc = crc_step(m_crc, b);
                if (m_len <= FRAME_CAP) begin
                    m_len++;
                end
                m_silence = 0;
                m_open = 1'b1;
            end
            ACT_TICK: begin
                if (m_open) begin
                    m_silence++;
                    // A gap setting of zero behaves like one.
                    if (m_silence >= m_gap) begin
                        n = 0;
                        if (m_len == REQ_LEN && m_crc == 16'h0000 && m_hdr[0] == m_dev) begin
                            start = {m_hdr[2], m_hdr[3]};
                            count = {m_hdr[4], m_hdr[5]};
                            msg[0] = m_hdr[0];
                            msg[1] = m_hdr[1];
                            if ((m_hdr[1] == FN_READ_HOLDING || m_hdr[1] == FN_READ_INPUT) &&
                                count != 0 && start < NUM_REGS &&
                                count <= NUM_REGS - start) begin
                                msg[2] = count * 2;
                                for (int i = 0; i < count; i++) begin
                                    c = (m_hdr[1] == FN_READ_HOLDING) ? m_hold[start + i]
                                                                      : m_inreg[start + i];
                                    msg[3 + 2 * i] = c[15:8];
                                    msg[4 + 2 * i] = c[7:0];
                                end
                                n = 3 + 2 * count;
                            end else if (m_hdr[1] == FN_WRITE_SINGLE && start < NUM_REGS) begin
                                m_hold[start] = {m_hdr[4], m_hdr[5]};
                                for (int i = 2; i < HDR_BYTES; i++) begin
                                    msg[i] = m_hdr[i];
                                end
                                n = HDR_BYTES;
                            end
                        end
                        if (n != 0) begin
                            c = CRC_INIT;
                            for (int i = 0; i < n; i++) begin
                                c = crc_step(c, msg[i]);
                            end
                            msg[n] = c[7:0];
                            msg[n + 1] = c[15:8];
                            for (int i = 0; i < n + 2; i++) begin
                                reply_bytes_due.push_back('{msg[i], i == n + 1});
                            end
                        end
                        // Served or dropped, the receiver starts over.
                        m_len = 0;
                        m_crc = CRC_INIT;
                        m_silence = 0;
                        m_open = 1'b0;
                    end
                end
            end
            ACT_INREG: begin
                if (idx < NUM_REGS) begin
                    m_inreg[idx] = val;
                end
            end
            default: ;
        endcase
    endtask

    // Input driver: offers queued events, holding each until it is taken, then waits
    // the number of idle cycles drawn for that event.
    rx_event_t next_ev;
    int        src_lag = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_lag <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_lag != 0) begin
                s_axis_tvalid <= 1'b0;
                src_lag <= src_lag - 1;
            end else if (rx_events.size() != 0) begin
                next_ev = rx_events.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, next_ev.val, next_ev.idx, next_ev.b};
                s_axis_tuser <= next_ev.act;
                src_lag <= next_ev.lag;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Reply receiver: stalls a random number of cycles after each byte, switching now
    // and then between idling and full speed. Once armed, it holds off for a long
    // stretch on the next reply so the slave backs up and stops taking input.
    int snk_lag = 0;
    int snk_draw;
    bit snk_idle_on = 1'b1;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_lag <= 0;
            snk_idle_on <= 1'b1;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done && m_axis_tvalid) begin
            m_axis_tready <= 1'b0;
            snk_lag <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (snk_lag != 0) begin
            m_axis_tready <= 1'b0;
            snk_lag <= snk_lag - 1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if ($urandom_range(0, 15) == 0) begin
                snk_idle_on <= !snk_idle_on;
            end
            snk_draw = snk_idle_on ? $urandom_range(0, 16) : 0;
            m_axis_tready <= (snk_draw == 0);
            snk_lag <= (snk_draw == 0) ? 0 : snk_draw - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks each accepted reply byte, then feeds each accepted input
    // event to the model. Replies never share an edge with the event that causes them.
    reply_byte_t due;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_bytes_due.size() == 0) begin
                    $error("unexpected reply byte: tx_byte %h, last_byte %b",
                           m_axis_tdata, m_axis_tlast);
                    err_count++;
                end else begin
                    due = reply_bytes_due.pop_front();
                    if (m_axis_tdata !== due.data) begin
                        $error("tx_byte: expected %h, actual %h", due.data, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== due.last) begin
                        $error("last_byte: expected %b, actual %b", due.last, m_axis_tlast);
                        err_count++;
                    end
                end
                bytes_seen++;
                if (m_axis_tlast) begin
                    frames_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_reply(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                              s_axis_tdata[24:9]);
                items_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modbus_rtu_register_slave test failed");
            $finish;
        end
    end

    task automatic push_event(input logic [1:0] act, input logic [7:0] b,
                              input logic idx, input logic [15:0] val);
        int lag;
        lag = src_idle_on ? $urandom_range(0, 16) : 0;
        rx_events.push_back('{act, b, idx, val, lag});
        events_queued++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) push_event(ACT_TICK, $urandom, $urandom, $urandom);
    endtask

    // A register update, an ignored action code, or a few ticks short of the gap.
    task automatic push_noise();
        case ($urandom_range(0, 2))
            0: push_event(ACT_INREG, $urandom, $urandom, $urandom);
            1: push_event(ACT_UNUSED, $urandom, $urandom, $urandom);
            default: begin
                if (m_gap > 1) begin
                    send_ticks($urandom_range(1, (m_gap > 7) ? 6 : m_gap - 1));
                end
            end
        endcase
    endtask

    // Sends a request with its CRC, then enough ticks to close it. A length below
    // eight cuts the request short; above eight, stray bytes follow a pause shorter than
    // the gap, so the frame grows too long.
    task automatic send_request(input logic [7:0] dev, input logic [7:0] fn,
                                input logic [15:0] start, input logic [15:0] word,
                                input int len, input bit bad_crc, input bit noisy);
        logic [7:0]  frame [0:REQ_LEN-1];
        logic [15:0] c;
        int          sent;
        frame[0] = dev;
        frame[1] = fn;
        frame[2] = start[15:8];
        frame[3] = start[7:0];
        frame[4] = word[15:8];
        frame[5] = word[7:0];
        c = CRC_INIT;
        for (int i = 0; i < HDR_BYTES; i++) begin
            c = crc_step(c, frame[i]);
        end
        frame[6] = c[7:0];
        frame[7] = c[15:8];
        if (bad_crc) begin
            frame[6 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
        end
        sent = (len < REQ_LEN) ? len : REQ_LEN;
        for (int i = 0; i < sent; i++) begin
            push_event(ACT_BYTE, frame[i], $urandom, $urandom);
            if (noisy && i < sent - 1 && $urandom_range(0, 4) == 0) begin
                push_noise();
            end
        end
        if (len > REQ_LEN) begin
            if (m_gap > 1) begin
                send_ticks((m_gap > 7) ? 6 : m_gap - 1);
            end
            repeat (len - REQ_LEN) push_event(ACT_BYTE, $urandom, $urandom, $urandom);
        end
        send_ticks((m_gap == 0) ? 1 : m_gap);
    endtask

    task automatic send_random_frame();
        int          kind;
        int          len;
        logic [7:0]  dev;
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] word;
        kind = $urandom_range(0, 99);
        src_idle_on = ($urandom_range(0, 3) != 0);
        dev = m_dev;
        if ($urandom_range(0, 9) == 0) begin
            dev = $urandom;
        end
        case ($urandom_range(0, 9))
            0: fn = $urandom;
            1, 2, 3: fn = FN_READ_HOLDING;
            4, 5, 6: fn = FN_READ_INPUT;
            default: fn = FN_WRITE_SINGLE;
        endcase
        start = $urandom_range(0, NUM_REGS);
        if ($urandom_range(0, 7) == 0) begin
            start = $urandom;
        end
        word = $urandom_range(0, NUM_REGS + 1);
        if (fn == FN_WRITE_SINGLE || $urandom_range(0, 7) == 0) begin
            word = $urandom;
        end
        len = REQ_LEN;
        if (kind < 10) begin
            len = $urandom_range(1, REQ_LEN - 1);
        end else if (kind < 18) begin
            len = $urandom_range(REQ_LEN + 1, REQ_LEN + 6);
        end
        send_request(dev, fn, start, word, len, kind >= 18 && kind < 26, 1'b1);
        repeat ($urandom_range(0, 2)) push_noise();
    endtask

    // One APB transfer: setup cycle, then access cycle; read data sampled mid-access.
    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_config();
        logic [31:0] rd;
        apb_access(1'b0, CFG_DEV_ADDR, 32'd0, rd);
        if (rd[7:0] !== m_dev) begin
            $error("device_address: expected %0d, actual %0d", m_dev, rd[7:0]);
            err_count++;
        end
        apb_access(1'b0, CFG_GAP, 32'd0, rd);
        if (rd[15:0] !== m_gap) begin
            $error("gap_ticks: expected %0d, actual %0d", m_gap, rd[15:0]);
            err_count++;
        end
    endtask

    // Waits until every event is taken and every reply byte has arrived, then lets
    // the slave finish any closing check that produced no reply.
    task automatic wait_quiet();
        while (rx_events.size() != 0 || s_axis_tvalid || reply_bytes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] dev, input logic [15:0] gap);
        logic [31:0] rd;
        wait_quiet();
        apb_access(1'b1, CFG_DEV_ADDR, {24'd0, dev}, rd);
        apb_access(1'b1, CFG_GAP, {16'd0, gap}, rd);
        m_dev = dev;
        m_gap = gap;
        check_config();
        settings_used++;
    endtask

    initial begin
        int target;
        logic [7:0] dev;
        logic [15:0] gap;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        check_config();
        settings_used++;

        // Ticks with no frame open, the unused action code, both input registers.
        send_ticks(2);
        push_event(ACT_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
        push_event(ACT_INREG, 8'h00, 1'b0, 16'hFFFF);
        push_event(ACT_INREG, 8'hFF, 1'b1, 16'h0000);
        // One request at the reset address and gap, sent at full speed.
        src_idle_on = 1'b0;
        send_request(DEV_ADDR_RESET, FN_READ_INPUT, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b0);

        set_config(8'hA5, 16'd1);
        src_idle_on = 1'b1;
        send_request(8'hA5, FN_WRITE_SINGLE, 16'd0, 16'hFFFF, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_WRITE_SINGLE, 16'd1, 16'h8001, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd1, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_INPUT, 16'd1, 16'd1, REQ_LEN, 1'b0, 1'b0);
        // Zero count, a range running off the end, and high bytes of start and count.
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd0, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd1, 16'd2, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_INPUT, 16'h0100, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_INPUT, 16'd0, 16'h0101, REQ_LEN, 1'b0, 1'b0);
        // Writes beyond the register bank.
        send_request(8'hA5, FN_WRITE_SINGLE, 16'd2, 16'h1234, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_WRITE_SINGLE, 16'h0100, 16'h4321, REQ_LEN, 1'b0, 1'b0);
        // Unknown functions, another device, a corrupted CRC.
        send_request(8'hA5, 8'h10, 16'd0, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, 8'h00, 16'd0, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, 8'hFF, 16'd0, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA4, FN_READ_HOLDING, 16'd0, 16'd1, REQ_LEN, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd1, REQ_LEN, 1'b1, 1'b0);
        // Short, long, and a frame longer than the length counter's cap.
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd1, REQ_LEN - 1, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd1, REQ_LEN + 1, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd1, FRAME_CAP + 44, 1'b0, 1'b0);
        send_request(8'hA5, FN_READ_HOLDING, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b0);

        // A gap of zero closes the frame on the first tick.
        set_config(8'h00, 16'd0);
        send_request(8'h00, FN_WRITE_SINGLE, 16'd1, 16'h00FF, REQ_LEN, 1'b0, 1'b0);
        send_request(8'h00, FN_READ_HOLDING, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b0);

        // Ticks just short of the gap must not end a frame; a byte restarts the count.
        set_config(8'hFF, 16'd3);
        send_request(8'hFF, FN_READ_HOLDING, 16'd0, 16'd2, REQ_LEN + 1, 1'b0, 1'b1);
        send_request(8'hFF, FN_READ_INPUT, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b1);

        // The longest gap, again at full speed.
        set_config(8'h7E, 16'hFFFF);
        src_idle_on = 1'b0;
        send_request(8'h7E, FN_READ_HOLDING, 16'd0, 16'd2, REQ_LEN, 1'b0, 1'b0);

        // Random phases; the second one also backs up the reply path for a while.
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(0, 3))
                0: dev = 8'h00;
                1: dev = 8'hFF;
                default: dev = $urandom;
            endcase
            gap = ($urandom_range(0, 9) == 0) ? 16'd0 : $urandom_range(1, 4);
            set_config(dev, gap);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            target = events_queued + 110;
            while (events_queued < target) begin
                send_random_frame();
            end
        end

        wait_quiet();
        if (reply_bytes_due.size() != 0) begin
            $error("%0d expected reply bytes never arrived", reply_bytes_due.size());
            err_count++;
        end
        $display("Covered %0d input items and %0d replies (%0d bytes) under %0d settings.",
                 items_taken, frames_seen, bytes_seen, settings_used);
        if (err_count == 0) begin
            $display("modbus_rtu_register_slave test passed");
        end else begin
            $display("modbus_rtu_register_slave test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mbrs_pkg.sv
hw/rtl/modbus_rtu_register_slave.sv
bench/testbench.sv
